[src/espg_pkg.sv]
// ----------------------------------------------------------------------------
// espg_pkg
// shared types and constants of the eased servo pulse generator
// ----------------------------------------------------------------------------
package espg_pkg;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CURVE_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BEGIN_PULSE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CHANGE_AMOUNT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DURATION_MS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RATE_SCALE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PULSE_MIN     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PULSE_MAX     = 3'd6;

  // input kinds
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // curve codes
  localparam logic [1:0] CURVE_LINEAR   = 2'd0;
  localparam logic [1:0] CURVE_EASE_IN  = 2'd1;
  localparam logic [1:0] CURVE_EASE_OUT = 2'd2;
  localparam logic [1:0] CURVE_EASE_IO  = 2'd3;

  // progress constants, Q2.16
  localparam logic [18:0] PROG_ONE = 19'h10000;
  localparam logic [18:0] PROG_TWO = 19'h20000;

  // register reset values
  localparam logic [1:0]         RST_CURVE_MODE    = 2'd0;
  localparam logic [11:0]        RST_BEGIN_PULSE   = 12'd1500;
  localparam logic signed [12:0] RST_CHANGE_AMOUNT = 13'sd0;
  localparam logic [15:0]        RST_DURATION_MS   = 16'd1000;
  localparam logic [15:0]        RST_RATE_SCALE    = 16'd256;
  localparam logic [11:0]        RST_PULSE_MIN     = 12'd500;
  localparam logic [11:0]        RST_PULSE_MAX     = 12'd2500;

  typedef struct packed {
    logic [1:0]         curve_mode;
    logic [11:0]        begin_pulse;
    logic signed [12:0] change_amount;
    logic [15:0]        duration_ms;
    logic [15:0]        rate_scale;
    logic [11:0]        pulse_min;
    logic [11:0]        pulse_max;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic        finished;
  } res_t;

endpackage

[src/espg_core.sv]
// ----------------------------------------------------------------------------
// espg_core
// bit-serial arithmetic sequencer: scale, divide, curve weight, pulse
// ----------------------------------------------------------------------------
module espg_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       elapsed_i,
  input  espg_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output espg_pkg::res_t    res_o
);
  import espg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_DIVSET = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_WSET   = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_WFIX   = 4'd6;
  localparam logic [3:0] S_MUL3   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [48:0] acc_q, acc_d;
  logic [35:0] mcand_q, mcand_d;
  logic [18:0] mplier_q, mplier_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] nbits_q, nbits_d;
  logic [17:0] p_q, p_d;
  logic        done_q, done_d;
  logic        ysn_q, ysn_d;
  logic        kf_q, kf_d;
  logic        sgn_q, sgn_d;

  // shared shift-add step, multiplier msb first
  logic [48:0] mul_next;
  assign mul_next = {acc_q[47:0], 1'b0} + (mplier_q[18] ? {13'b0, mcand_q} : 49'd0);

  // divider step
  logic [16:0] div_t;
  logic        div_ge;
  logic [16:0] div_sub;
  assign div_t   = {rem_q, nbits_q[16]};
  assign div_ge  = div_t >= {1'b0, cfg_i.duration_ms};
  assign div_sub = div_t - {1'b0, cfg_i.duration_ms};

  // saturation and end-of-move tests on the scaled time
  logic [47:0] scaled;
  logic        sat;
  assign scaled = acc_q[47:0];
  assign sat    = scaled >= {23'b0, cfg_i.duration_ms, 9'b0};

  // curve operands
  logic [18:0] p2, pe, rr, xs, ys;
  logic        ysn, kf;
  always_comb begin
    p2  = {p_q, 1'b0};
    pe  = {1'b0, p_q};
    rr  = p2 - PROG_ONE;
    xs  = pe;
    ys  = PROG_TWO;
    ysn = 1'b0;
    kf  = 1'b0;
    case (cfg_i.curve_mode)
      CURVE_LINEAR: begin
        xs = pe;
        ys = PROG_TWO;
      end
      CURVE_EASE_IN: begin
        xs = pe;
        ys = p2;
      end
      CURVE_EASE_OUT: begin
        xs = p2;
        ys = PROG_TWO - pe;
      end
      default: begin
        if (p2 < PROG_ONE) begin
          xs = p2;
          ys = p2;
        end else begin
          xs = rr;
          kf = 1'b1;
          if (rr <= PROG_TWO) begin
            ys = PROG_TWO - rr;
          end else begin
            ys  = rr - PROG_TWO;
            ysn = 1'b1;
          end
        end
      end
    endcase
  end

  // weight with 33 fraction bits, then magnitudes for the last product
  logic [37:0] kterm, xyx, wv, wabs;
  logic [12:0] cmag;
  logic        cneg;
  always_comb begin
    kterm = kf_q ? (38'd1 << 32) : 38'd0;
    xyx   = {2'b0, acc_q[35:0]};
    wv    = ysn_q ? (kterm - xyx) : (kterm + xyx);
    wabs  = wv[37] ? (~wv + 38'd1) : wv;
    cneg  = cfg_i.change_amount[12];
    cmag  = cneg ? (~cfg_i.change_amount + 13'd1) : cfg_i.change_amount;
  end

  // truncate toward zero, offset and clamp
  logic [15:0]        dmag;
  logic signed [17:0] delta, sum, lo, hi, clamped;
  always_comb begin
    dmag  = acc_q[48:33];
    delta = sgn_q ? -$signed({2'b0, dmag}) : $signed({2'b0, dmag});
    sum   = $signed({6'b0, cfg_i.begin_pulse}) + delta;
    lo    = $signed({6'b0, cfg_i.pulse_min});
    hi    = $signed({6'b0, cfg_i.pulse_max});
    clamped = (sum < lo) ? lo : sum;
    if (clamped > hi) clamped = hi;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    nbits_d  = nbits_q;
    p_d      = p_q;
    done_d   = done_q;
    ysn_d    = ysn_q;
    kf_d     = kf_q;
    sgn_d    = sgn_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_d    = '0;
          mcand_d  = {4'b0, elapsed_i};
          mplier_d = {cfg_i.rate_scale, 3'b0};
          cnt_d    = 5'd16;
          state_d  = S_MUL1;
        end
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        acc_d    = mul_next;
        mplier_d = {mplier_q[17:0], 1'b0};
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          case (state_q)
            S_MUL1:  state_d = S_DIVSET;
            S_MUL2:  state_d = S_WFIX;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_DIVSET: begin
        done_d = scaled >= {24'b0, cfg_i.duration_ms, 8'b0};
        if (sat) begin
          p_d     = PROG_TWO[17:0];
          state_d = S_WSET;
        end else begin
          rem_d   = scaled[24:9];
          nbits_d = {scaled[8:0], 8'b0};
          p_d     = '0;
          cnt_d   = 5'd17;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d   = div_ge ? div_sub[15:0] : div_t[15:0];
        p_d     = {p_q[16:0], div_ge};
        nbits_d = {nbits_q[15:0], 1'b0};
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == 5'd1) state_d = S_WSET;
      end
      S_WSET: begin
        acc_d    = '0;
        mcand_d  = {17'b0, xs};
        mplier_d = ys;
        ysn_d    = ysn;
        kf_d     = kf;
        cnt_d    = 5'd19;
        state_d  = S_MUL2;
      end
      S_WFIX: begin
        acc_d    = '0;
        mcand_d  = wabs[35:0];
        mplier_d = {cmag, 6'b0};
        sgn_d    = wv[37] ^ cneg;
        cnt_d    = 5'd13;
        state_d  = S_MUL3;
      end
      S_FIN: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    nbits_q  <= nbits_d;
    p_q      <= p_d;
    done_q   <= done_d;
    ysn_q    <= ysn_d;
    kf_q     <= kf_d;
    sgn_q    <= sgn_d;
  end

  assign res_valid_o    = state_q == S_FIN;
  assign res_o.pulse_us = clamped[11:0];
  assign res_o.finished = done_q;

endmodule

[src/eased_servo_pulse_generator_top.sv]
// ----------------------------------------------------------------------------
// eased_servo_pulse_generator_top
// servo move profile generator with quadratic easing curves
// ----------------------------------------------------------------------------
// usage:
//   slave stream: tuser is the kind (0 start a move, 1 update), tdata the
//   millisecond timestamp. master stream: tdata carries the pulse width,
//   tuser the moving and finished flags. one result transfer per input.
//   a start transfer, or an update while no move is armed, is answered from
//   the output register in the cycle after acceptance.
//   an update during a move runs through the bit-serial core: time scaling,
//   a setup step, the divider (skipped when progress saturates), a setup
//   step, the weight multiply, a setup step, the change multiply and a
//   result state. the core uses a shift-add multiplier and a restoring
//   divider; one update is in flight at a time.
//   configuration writes are taken every cycle through cfg_we_i.
//   reset puts the configuration registers at their reset values with no move armed.
//   when the receiver stalls, the result holds in the output register and a
//   finished core result waits in the core; input is refused meanwhile.
// ----------------------------------------------------------------------------
module eased_servo_pulse_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [espg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [espg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // now_ms[31:0]
  input  logic                           s_axis_tuser,   // action
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // pulse_us[11:0], zero pad
  output logic [1:0]                     m_axis_tuser    // moving, finished
);
  import espg_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve_mode    <= RST_CURVE_MODE;
      cfg_q.begin_pulse   <= RST_BEGIN_PULSE;
      cfg_q.change_amount <= RST_CHANGE_AMOUNT;
      cfg_q.duration_ms   <= RST_DURATION_MS;
      cfg_q.rate_scale    <= RST_RATE_SCALE;
      cfg_q.pulse_min     <= RST_PULSE_MIN;
      cfg_q.pulse_max     <= RST_PULSE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CURVE_MODE:    cfg_q.curve_mode    <= cfg_wdata_i[1:0];
        REG_BEGIN_PULSE:   cfg_q.begin_pulse   <= cfg_wdata_i[11:0];
        REG_CHANGE_AMOUNT: cfg_q.change_amount <= cfg_wdata_i[12:0];
        REG_DURATION_MS:   cfg_q.duration_ms   <= cfg_wdata_i;
        REG_RATE_SCALE:    cfg_q.rate_scale    <= cfg_wdata_i;
        REG_PULSE_MIN:     cfg_q.pulse_min     <= cfg_wdata_i[11:0];
        REG_PULSE_MAX:     cfg_q.pulse_max     <= cfg_wdata_i[11:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // move state
  logic        active_q, latched_q, busy_q;
  logic [31:0] start_q;

  // output register
  logic        out_valid_q;
  logic [11:0] out_pulse_q;
  logic        out_moving_q, out_fin_q;

  logic  res_valid;
  res_t  res;

  logic  out_free, s_fire, res_take, core_start;
  logic  [31:0] elapsed;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !busy_q && out_free;
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign res_take   = res_valid && out_free;
  // update during a move goes to the core
  assign core_start = s_fire && (s_axis_tuser == ACT_UPDATE) && active_q;
  // first update after a start sees zero elapsed time
  assign elapsed    = latched_q ? (s_axis_tdata - start_q) : 32'd0;

  espg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (core_start),
    .elapsed_i   (elapsed),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (out_free),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      latched_q   <= 1'b0;
      busy_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result loads the output register, a taken one empties it
      if ((s_fire && !core_start) || res_take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s_fire) begin
        if (s_axis_tuser == ACT_START) begin
          active_q  <= 1'b1;
          latched_q <= 1'b0;
        end else if (active_q) begin
          busy_q <= 1'b1;
          if (!latched_q) begin
            start_q   <= s_axis_tdata;
            latched_q <= 1'b1;
          end
        end
      end
      if (res_take) begin
        busy_q <= 1'b0;
        // move ends when scaled time reaches the duration
        if (res.finished) begin
          active_q  <= 1'b0;
          latched_q <= 1'b0;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire && !core_start) begin
      out_pulse_q  <= '0;
      out_moving_q <= (s_axis_tuser == ACT_START);
      out_fin_q    <= 1'b0;
    end else if (res_take) begin
      out_pulse_q  <= res.pulse_us;
      out_moving_q <= !res.finished;
      out_fin_q    <= res.finished;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_pulse_q};
  assign m_axis_tuser  = {out_fin_q, out_moving_q};

endmodule

[src/espg_checker.sv]
// ----------------------------------------------------------------------------
// espg_checker
// port-level checks on the eased servo pulse generator
// ----------------------------------------------------------------------------
module espg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a start transfer is answered next cycle with a zero pulse and moving set
  a_start_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=>
      m_axis_tvalid && (m_axis_tdata == 16'h0000) && (m_axis_tuser == 2'b01))
    else $error("start transfer not answered");

  // a finished move is no longer moving
  a_fin_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("finished and moving together");

  // idle update gives a zero pulse, pad bits always zero
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[15:12] == 4'h0) &&
      (m_axis_tuser[0] || m_axis_tuser[1] || (m_axis_tdata == 16'h0000)))
    else $error("bad pulse on idle result");

endmodule

bind eased_servo_pulse_generator_top espg_checker u_espg_checker (.*);
